// ----- hdl/fbpa_pkg.sv -----
// Shared types and constants for the fixed block pool allocator.
`default_nettype none

package fbpa_pkg;

  localparam int unsigned ADDR_W         = 48;
  localparam int unsigned SIZE_W         = 32;
  localparam int unsigned BSIZE_W        = 17;
  localparam int unsigned OUT_IDX_W      = 10;
  localparam int unsigned OUT_CNT_W      = 11;
  localparam int unsigned MAX_IDX_W      = 16;
  localparam int unsigned CFG_DATA_W     = 64;
  localparam int unsigned CFG_ADDR_W     = 4;
  localparam int unsigned CMD_FIFO_DEPTH = 2;

  localparam logic [BSIZE_W-1:0] BSIZE_RESET = 17'd64;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // register select, taken from the top bit of paddr
  localparam logic CFG_SEL_BASE  = 1'b0;
  localparam logic CFG_SEL_BSIZE = 1'b1;

  typedef enum logic [2:0] {
    ST_GRANTED      = 3'd0,
    ST_FREED        = 3'd1,
    ST_BAD_SIZE     = 3'd2,
    ST_EMPTY        = 3'd3,
    ST_OUT_OF_RANGE = 3'd4,
    ST_MISALIGNED   = 3'd5,
    ST_DOUBLE_FREE  = 3'd6,
    ST_CORRUPT      = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_REJECT
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e                op;
    status_e                reject_status;
    logic [MAX_IDX_W-1:0]   index;
  } cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  base_address;
    logic [BSIZE_W-1:0] blk_bytes;
  } cfg_t;

endpackage

`default_nettype wire

// ----- hdl/fbpa_if.sv -----
// Request and response channel interfaces of the block pool allocator.
`default_nettype none

interface fbpa_req_if import fbpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [SIZE_W-1:0] request_size;
  logic [ADDR_W-1:0] free_address;

  modport source (output valid, mode, request_size, free_address, input ready);
  modport sink   (input valid, mode, request_size, free_address, output ready);
endinterface

interface fbpa_rsp_if import fbpa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  status_e              status;
  logic [ADDR_W-1:0]    block_address;
  logic [OUT_IDX_W-1:0] block_index;
  logic [OUT_CNT_W-1:0] blocks_free;

  modport source (output valid, status, block_address, block_index, blocks_free,
                  input ready);
  modport sink   (input valid, status, block_address, block_index, blocks_free,
                  output ready);
endinterface

`default_nettype wire

// ----- hdl/fbpa_cmd_fifo.sv -----
// Short command queue between the classifying front end and the list engine.
`default_nettype none

module fbpa_cmd_fifo import fbpa_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  wire  pop_ready_i,
  output cmd_t pop_cmd_o
);

  localparam int unsigned PTR_W = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

  cmd_t             entry_q [CMD_FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_W'(CMD_FIFO_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/fbpa_front.sv -----
// Front end: takes request beats, checks size and range, divides free offsets.
`default_nettype none

module fbpa_front import fbpa_pkg::*; #(
  parameter int unsigned NUM_BLOCKS = 1024
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  cfg_t        cfg_i,
  fbpa_req_if.sink    req_i,
  output logic        cmd_valid_o,
  input  wire         cmd_ready_i,
  output cmd_t        cmd_o
);

  localparam int unsigned IW     = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned RW     = BSIZE_W + IW;
  localparam int unsigned STEP_W = (IW > 1) ? $clog2(IW) : 1;

  typedef enum logic [2:0] {
    F_IDLE,
    F_OFFSET,
    F_RANGE,
    F_DIV,
    F_PUSH
  } fstate_e;

  fstate_e           state_q, state_d;
  logic              mode_q, mode_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [ADDR_W-1:0] offset_q, offset_d;
  logic              below_q, below_d;
  logic [RW-1:0]     rem_q, rem_d;
  logic [IW-1:0]     quot_q, quot_d;
  logic [STEP_W-1:0] step_q, step_d;
  cmd_t              cmd_q, cmd_d;
  logic [RW-1:0]     region_q;

  logic [RW-1:0]     div_shift;
  logic [RW-1:0]     rem_next;
  logic [IW-1:0]     quot_next;
  logic              div_take;

  assign req_i.ready = (state_q == F_IDLE);
  assign cmd_valid_o = (state_q == F_PUSH);
  assign cmd_o       = cmd_q;

  // pool size in bytes, registered from the block size register
  always_ff @(posedge clk_i) begin
    region_q <= RW'(cfg_i.blk_bytes) * RW'(NUM_BLOCKS);
  end

  always_comb begin
    state_d  = state_q;
    mode_d   = mode_q;
    size_d   = size_q;
    addr_d   = addr_q;
    offset_d = offset_q;
    below_d  = below_q;
    rem_d    = rem_q;
    quot_d   = quot_q;
    step_d   = step_q;
    cmd_d    = cmd_q;

    // restoring divide, one quotient bit a cycle, MSB first
    div_shift = RW'(cfg_i.blk_bytes) << step_q;
    div_take  = (rem_q >= div_shift);
    rem_next  = div_take ? (rem_q - div_shift) : rem_q;
    quot_next = quot_q;
    quot_next[step_q] = div_take;

    unique case (state_q)
      F_IDLE: begin
        if (req_i.valid) begin
          mode_d  = req_i.mode;
          size_d  = req_i.request_size;
          addr_d  = req_i.free_address;
          state_d = F_OFFSET;
        end
      end
      F_OFFSET: begin
        if (mode_q == MODE_ALLOC) begin
          if (size_q == '0 || size_q > SIZE_W'(cfg_i.blk_bytes)) begin
            cmd_d = '{op: OP_REJECT, reject_status: ST_BAD_SIZE, index: '0};
          end else begin
            cmd_d = '{op: OP_ALLOC, reject_status: ST_GRANTED, index: '0};
          end
          state_d = F_PUSH;
        end else begin
          {below_d, offset_d} = {1'b0, addr_q} - {1'b0, cfg_i.base_address};
          state_d = F_RANGE;
        end
      end
      F_RANGE: begin
        if (below_q || offset_q >= ADDR_W'(region_q) || cfg_i.blk_bytes == '0) begin
          cmd_d   = '{op: OP_REJECT, reject_status: ST_OUT_OF_RANGE, index: '0};
          state_d = F_PUSH;
        end else begin
          rem_d   = offset_q[RW-1:0];
          quot_d  = '0;
          step_d  = STEP_W'(IW - 1);
          state_d = F_DIV;
        end
      end
      F_DIV: begin
        rem_d  = rem_next;
        quot_d = quot_next;
        if (step_q == '0) begin
          if (rem_next != '0) begin
            cmd_d = '{op: OP_REJECT, reject_status: ST_MISALIGNED, index: '0};
          end else begin
            cmd_d = '{op: OP_FREE, reject_status: ST_FREED,
                      index: MAX_IDX_W'(quot_next)};
          end
          state_d = F_PUSH;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      F_PUSH: begin
        if (cmd_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      mode_q   <= MODE_ALLOC;
      size_q   <= '0;
      addr_q   <= '0;
      offset_q <= '0;
      below_q  <= 1'b0;
      rem_q    <= '0;
      quot_q   <= '0;
      step_q   <= '0;
      cmd_q    <= '{op: OP_REJECT, reject_status: ST_BAD_SIZE, index: '0};
    end else begin
      state_q  <= state_d;
      mode_q   <= mode_d;
      size_q   <= size_d;
      addr_q   <= addr_d;
      offset_q <= offset_d;
      below_q  <= below_d;
      rem_q    <= rem_d;
      quot_q   <= quot_d;
      step_q   <= step_d;
      cmd_q    <= cmd_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/fbpa_back.sv -----
// Back end: free list, link and map memories, free count and result register.
`default_nettype none

module fbpa_back import fbpa_pkg::*; #(
  parameter int unsigned NUM_BLOCKS = 1024,
  parameter int unsigned ADDR_WIDTH = 48
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  cfg_t        cfg_i,
  input  wire         cmd_valid_i,
  output logic        cmd_ready_o,
  input  cmd_t        cmd_i,
  fbpa_rsp_if.source  rsp_o
);

  localparam int unsigned IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned CW = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned PW = IW + BSIZE_W;
  localparam int unsigned AW = (ADDR_WIDTH < ADDR_W) ? ADDR_WIDTH : ADDR_W;

  typedef enum logic [1:0] {
    B_IDLE,
    B_LOOKUP,
    B_ADDR
  } bstate_e;

  // link entry: {valid, next index}
  logic [IW:0]  link_mem [NUM_BLOCKS];
  logic         map_mem  [NUM_BLOCKS];
  logic [IW:0]  link_rd_q;
  logic         map_rd_q;
  logic [IW-1:0] rd_addr;
  logic         map_we, map_wdata, link_we;
  logic [IW:0]  link_wdata;

  bstate_e              state_q, state_d;
  logic                 is_alloc_q, is_alloc_d;
  logic [IW-1:0]        idx_q, idx_d;
  logic [IW-1:0]        head_q, head_d;
  logic                 head_valid_q, head_valid_d;
  logic [CW-1:0]        mark_q, mark_d;
  logic [CW-1:0]        free_total_q, free_total_d;
  logic [PW-1:0]        prod_q, prod_d;
  logic                 out_valid_q, out_valid_d;
  status_e              status_q, status_d;
  logic [ADDR_W-1:0]    out_addr_q, out_addr_d;
  logic [OUT_IDX_W-1:0] out_index_q, out_index_d;
  logic [OUT_CNT_W-1:0] out_count_q, out_count_d;

  logic                 fresh, map_bit;
  logic [IW-1:0]        link_prev;
  logic [IW:0]          link_next;
  logic [AW-1:0]        addr_sum;

  assign cmd_ready_o         = (state_q == B_IDLE) && !out_valid_q;
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = status_q;
  assign rsp_o.block_address = out_addr_q;
  assign rsp_o.block_index   = out_index_q;
  assign rsp_o.blocks_free   = out_count_q;

  assign rd_addr = (cmd_i.op == OP_ALLOC) ? head_q : IW'(cmd_i.index);

  // entries below the mark were never popped, so they still hold the reset
  // pattern: free, linked to the next lower index
  assign fresh     = (CW'(idx_q) < mark_q);
  assign map_bit   = fresh || map_rd_q;
  assign link_prev = (idx_q == '0) ? '0 : idx_q - 1'b1;
  assign link_next = fresh ? {(idx_q != '0), link_prev} : link_rd_q;
  assign addr_sum  = AW'(cfg_i.base_address) + AW'(prod_q);

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[idx_q] <= map_wdata;
    end
    map_rd_q <= map_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[idx_q] <= link_wdata;
    end
    link_rd_q <= link_mem[rd_addr];
  end

  always_comb begin
    state_d      = state_q;
    is_alloc_d   = is_alloc_q;
    idx_d        = idx_q;
    head_d       = head_q;
    head_valid_d = head_valid_q;
    mark_d       = mark_q;
    free_total_d = free_total_q;
    prod_d       = prod_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    status_d     = status_q;
    out_addr_d   = out_addr_q;
    out_index_d  = out_index_q;
    out_count_d  = out_count_q;
    map_we       = 1'b0;
    map_wdata    = 1'b0;
    link_we      = 1'b0;
    link_wdata   = {head_valid_q, head_q};

    unique case (state_q)
      B_IDLE: begin
        if (cmd_valid_i && !out_valid_q) begin
          unique case (cmd_i.op)
            OP_REJECT: begin
              out_valid_d = 1'b1;
              status_d    = cmd_i.reject_status;
              out_addr_d  = '0;
              out_index_d = '0;
              out_count_d = OUT_CNT_W'(free_total_q);
            end
            OP_ALLOC: begin
              if (!head_valid_q) begin
                out_valid_d = 1'b1;
                status_d    = ST_EMPTY;
                out_addr_d  = '0;
                out_index_d = '0;
                out_count_d = OUT_CNT_W'(free_total_q);
              end else begin
                idx_d      = head_q;
                is_alloc_d = 1'b1;
                state_d    = B_LOOKUP;
              end
            end
            OP_FREE: begin
              idx_d      = IW'(cmd_i.index);
              is_alloc_d = 1'b0;
              state_d    = B_LOOKUP;
            end
            default: state_d = B_IDLE;
          endcase
        end
      end
      B_LOOKUP: begin
        if (is_alloc_q) begin
          head_d       = link_next[IW-1:0];
          head_valid_d = link_next[IW];
          if (fresh) begin
            mark_d = CW'(idx_q);
          end
          if (!map_bit) begin
            // block already out: it stays off the list
            out_valid_d = 1'b1;
            status_d    = ST_CORRUPT;
            out_addr_d  = '0;
            out_index_d = '0;
            out_count_d = OUT_CNT_W'(free_total_q);
            state_d     = B_IDLE;
          end else begin
            map_we    = 1'b1;
            map_wdata = 1'b0;
            if (free_total_q != '0) begin
              free_total_d = free_total_q - 1'b1;
            end
            prod_d  = PW'(idx_q) * PW'(cfg_i.blk_bytes);
            state_d = B_ADDR;
          end
        end else begin
          if (map_bit) begin
            out_valid_d = 1'b1;
            status_d    = ST_DOUBLE_FREE;
            out_addr_d  = '0;
            out_index_d = '0;
            out_count_d = OUT_CNT_W'(free_total_q);
          end else begin
            map_we       = 1'b1;
            map_wdata    = 1'b1;
            link_we      = 1'b1;
            head_d       = idx_q;
            head_valid_d = 1'b1;
            if (free_total_q < CW'(NUM_BLOCKS)) begin
              free_total_d = free_total_q + 1'b1;
            end
            out_valid_d = 1'b1;
            status_d    = ST_FREED;
            out_addr_d  = '0;
            out_index_d = OUT_IDX_W'(idx_q);
            out_count_d = OUT_CNT_W'(free_total_d);
          end
          state_d = B_IDLE;
        end
      end
      B_ADDR: begin
        out_valid_d = 1'b1;
        status_d    = ST_GRANTED;
        out_addr_d  = ADDR_W'(addr_sum);
        out_index_d = OUT_IDX_W'(idx_q);
        out_count_d = OUT_CNT_W'(free_total_q);
        state_d     = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= B_IDLE;
      is_alloc_q   <= 1'b0;
      idx_q        <= '0;
      head_q       <= IW'(NUM_BLOCKS - 1);
      head_valid_q <= 1'b1;
      mark_q       <= CW'(NUM_BLOCKS);
      free_total_q <= CW'(NUM_BLOCKS);
      prod_q       <= '0;
      out_valid_q  <= 1'b0;
      status_q     <= ST_GRANTED;
      out_addr_q   <= '0;
      out_index_q  <= '0;
      out_count_q  <= '0;
    end else begin
      state_q      <= state_d;
      is_alloc_q   <= is_alloc_d;
      idx_q        <= idx_d;
      head_q       <= head_d;
      head_valid_q <= head_valid_d;
      mark_q       <= mark_d;
      free_total_q <= free_total_d;
      prod_q       <= prod_d;
      out_valid_q  <= out_valid_d;
      status_q     <= status_d;
      out_addr_q   <= out_addr_d;
      out_index_q  <= out_index_d;
      out_count_q  <= out_count_d;
    end
  end

  a_busy_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != B_IDLE) |-> !out_valid_q)
    else $error("result register loaded while a command is in flight");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_total_q <= CW'(NUM_BLOCKS))
    else $error("free count above pool size");

  a_empty_list_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_valid_q |-> (free_total_q == '0))
    else $error("free list empty but free count non-zero");

  a_mark_descends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mark_q != $past(mark_q)) |-> (mark_q == $past(mark_q) - 1'b1))
    else $error("untouched region shrank by more than one block");

endmodule

`default_nettype wire

// ----- hdl/fixed_block_pool_allocator.sv -----
// Top level of the fixed block pool allocator: config registers and the three stages.
//
// Hands out and takes back equal-size blocks of a pool of NUM_BLOCKS blocks that
// starts at base_address (APB byte address 0, 64-bit data) and has a programmable
// block length in bytes (address 8). Each request beat gives exactly one response
// beat, in order. The front end checks the size of an allocate and pushes its
// command; a free goes through the offset, range and divide states before its
// push, the restoring divider finding the block index from the byte offset one
// quotient bit per cycle. No new request is taken until the command is pushed.
// The list engine sits behind a two-entry command queue; its pace is set by its
// registered reads of the link and free-map memories and the address
// multiply. The reset pattern of those memories is served by a low-water mark
// of untouched blocks, so there is no clearing pass and requests are taken
// straight out of reset. Configuration is only to be written with the block idle.
`default_nettype none

module fixed_block_pool_allocator import fbpa_pkg::*; #(
  parameter int unsigned NUM_BLOCKS = 1024,
  parameter int unsigned ADDR_WIDTH = 48
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire  [CFG_ADDR_W-1:0] paddr,
  input  wire  [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  fbpa_req_if.sink              req_i,
  fbpa_rsp_if.source            rsp_o
);

  cfg_t cfg_q;
  logic cfg_we;
  logic cfg_sel;
  logic cmd_push_valid, cmd_push_ready;
  logic cmd_pop_valid, cmd_pop_ready;
  cmd_t cmd_push, cmd_pop;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_sel = paddr[CFG_ADDR_W-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_address <= '0;
      cfg_q.blk_bytes    <= BSIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_sel)
        CFG_SEL_BASE:  cfg_q.base_address <= pwdata[ADDR_W-1:0];
        CFG_SEL_BSIZE: cfg_q.blk_bytes    <= pwdata[BSIZE_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      CFG_SEL_BASE:  prdata = CFG_DATA_W'(cfg_q.base_address);
      CFG_SEL_BSIZE: prdata = CFG_DATA_W'(cfg_q.blk_bytes);
    endcase
  end

  fbpa_front #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .req_i       (req_i),
    .cmd_valid_o (cmd_push_valid),
    .cmd_ready_i (cmd_push_ready),
    .cmd_o       (cmd_push)
  );

  fbpa_cmd_fifo u_cmd_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (cmd_push_valid),
    .push_ready_o (cmd_push_ready),
    .push_cmd_i   (cmd_push),
    .pop_valid_o  (cmd_pop_valid),
    .pop_ready_i  (cmd_pop_ready),
    .pop_cmd_o    (cmd_pop)
  );

  fbpa_back #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_pop_valid),
    .cmd_ready_o (cmd_pop_ready),
    .cmd_i       (cmd_pop),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire

// ----- tb/sv/fixed_block_pool_allocator_test.sv -----
// Testbench for the fixed block pool allocator: directed and random traffic checked against a pool model.
`timescale 1ns / 100ps

module fixed_block_pool_allocator_test;
  import fbpa_pkg::*;

  localparam int unsigned POOL_BLOCKS  = 1024;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned SETTLE_TICKS = 48;

  typedef struct {
    status_e              status;
    logic [ADDR_W-1:0]    addr;
    logic [OUT_IDX_W-1:0] index;
    logic [OUT_CNT_W-1:0] free_cnt;
  } outcome_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  fbpa_req_if req_ch();
  fbpa_rsp_if rsp_ch();

  fixed_block_pool_allocator dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req_i   (req_ch),
    .rsp_o   (rsp_ch)
  );

  // pool model state
  logic [ADDR_W-1:0]  pool_base;
  logic [BSIZE_W-1:0] blk_size;
  int unsigned        free_head;
  bit                 head_live;
  int unsigned        next_free [POOL_BLOCKS];
  bit                 next_live [POOL_BLOCKS];
  bit                 is_free   [POOL_BLOCKS];
  int unsigned        free_blocks;
  int unsigned        held_blocks[$];

  outcome_t    pool_outcomes[$];
  int unsigned mismatches = 0;
  bit          jitter_on = 1'b1;

  always #10 clk_i = ~clk_i;

  function automatic void report_mismatch(input string what, input logic [63:0] exp_v,
                                          input logic [63:0] got_v);
    if (mismatches < 10)
      $display("mismatch on %s: expected 0x%0h, got 0x%0h at %0t", what, exp_v, got_v, $time);
    mismatches++;
  endfunction

  function automatic void reset_pool_model();
    int unsigned k;
    pool_base = '0;
    blk_size  = BSIZE_RESET;
    for (k = 0; k < POOL_BLOCKS; k++) begin
      next_free[k] = (k > 0) ? k - 1 : 0;
      next_live[k] = (k > 0);
      is_free[k]   = 1'b1;
    end
    free_head   = POOL_BLOCKS - 1;
    head_live   = 1'b1;
    free_blocks = POOL_BLOCKS;
    held_blocks.delete();
  endfunction

  function automatic outcome_t predict_request(input logic md, input logic [SIZE_W-1:0] sz,
                                               input logic [ADDR_W-1:0] fa);
    outcome_t    o;
    logic [63:0] region;
    logic [63:0] offset;
    int unsigned idx;
    int          k;
    o.status = ST_GRANTED;
    o.addr   = '0;
    o.index  = '0;
    if (md == MODE_ALLOC) begin
      if (sz == 0 || 64'(sz) > 64'(blk_size)) begin
        o.status = ST_BAD_SIZE;
      end else if (!head_live) begin
        o.status = ST_EMPTY;
      end else begin
        idx       = free_head;
        head_live = next_live[idx];
        free_head = next_free[idx];
        // a popped block already marked in use is dropped from the list
        if (!is_free[idx]) begin
          o.status = ST_CORRUPT;
        end else begin
          is_free[idx] = 1'b0;
          if (free_blocks > 0) free_blocks--;
          o.addr  = ADDR_W'(64'(pool_base) + 64'(idx) * 64'(blk_size));
          o.index = OUT_IDX_W'(idx);
          held_blocks.push_back(idx);
        end
      end
    end else begin
      region   = 64'(blk_size) * 64'(POOL_BLOCKS);
      offset   = 64'(fa) - 64'(pool_base);
      o.status = ST_FREED;
      if (fa < pool_base || offset >= region || blk_size == 0) begin
        o.status = ST_OUT_OF_RANGE;
      end else if (offset % 64'(blk_size) != 0) begin
        o.status = ST_MISALIGNED;
      end else begin
        idx = int'(offset / 64'(blk_size));
        if (is_free[idx]) begin
          o.status = ST_DOUBLE_FREE;
        end else begin
          is_free[idx]   = 1'b1;
          next_free[idx] = free_head;
          next_live[idx] = head_live;
          free_head      = idx;
          head_live      = 1'b1;
          if (free_blocks < POOL_BLOCKS) free_blocks++;
          o.index = OUT_IDX_W'(idx);
          for (k = 0; k < held_blocks.size(); k++) begin
            if (held_blocks[k] == idx) begin
              held_blocks.delete(k);
              break;
            end
          end
        end
      end
    end
    o.free_cnt = OUT_CNT_W'(free_blocks);
    return o;
  endfunction

  // one request beat; called at a falling edge, returns at a falling edge
  task automatic send_request(input logic md, input logic [SIZE_W-1:0] sz,
                              input logic [ADDR_W-1:0] fa, output status_e st);
    outcome_t o;
    while (jitter_on && $urandom_range(99) < 37) begin
      req_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid        = 1'b1;
    req_ch.mode         = md;
    req_ch.request_size = sz;
    req_ch.free_address = fa;
    do @(posedge clk_i); while (!req_ch.ready);
    o = predict_request(md, sz, fa);
    pool_outcomes.push_back(o);
    st = o.status;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    req_ch.valid = 1'b0;
    while (pool_outcomes.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // APB write then read-back of one register
  task automatic write_reg(input logic sel, input logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] mask;
    mask    = (sel == CFG_SEL_BASE) ? (64'd1 << ADDR_W) - 1 : (64'd1 << BSIZE_W) - 1;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = CFG_ADDR_W'({sel, 3'b000});
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (sel == CFG_SEL_BASE) pool_base = ADDR_W'(value);
    else blk_size = BSIZE_W'(value);
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if ((prdata & mask) !== (value & mask))
      report_mismatch("register read-back", value & mask, prdata & mask);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic random_traffic(input int unsigned count, input int unsigned alloc_pct,
                                input int unsigned empties_wanted);
    logic              md;
    logic [SIZE_W-1:0] sz;
    logic [ADDR_W-1:0] fa;
    logic [63:0]       region;
    status_e           st;
    int unsigned       pick;
    int unsigned       idx;
    int unsigned       tries;
    int unsigned       sent;
    int unsigned       empties;
    sent    = 0;
    empties = 0;
    while (sent < count || empties < empties_wanted) begin
      region = 64'(blk_size) * 64'(POOL_BLOCKS);
      sz     = $urandom;
      fa     = ADDR_W'({$urandom, $urandom});
      pick   = $urandom_range(9);
      if ($urandom_range(99) < alloc_pct) begin
        md = MODE_ALLOC;
        if (pick == 0) sz = '0;
        else if (pick == 1) sz = SIZE_W'(blk_size) + SIZE_W'($urandom_range(1, 300));
        else if (pick >= 3) sz = SIZE_W'($urandom_range(1, blk_size));
      end else begin
        md = MODE_FREE;
        if (pick < 6 && held_blocks.size() != 0) begin
          idx = held_blocks[$urandom_range(held_blocks.size() - 1)];
          fa  = ADDR_W'(64'(pool_base) + 64'(idx) * 64'(blk_size));
        end else if (pick == 6) begin
          idx = $urandom_range(POOL_BLOCKS - 1);
          fa  = ADDR_W'(64'(pool_base) + 64'(idx) * 64'(blk_size) +
                        64'($urandom_range(1, blk_size - 1)));
        end else if (pick == 7) begin
          // aim at a block that is already on the free list
          idx = $urandom_range(POOL_BLOCKS - 1);
          for (tries = 0; tries < 8 && !is_free[idx]; tries++)
            idx = $urandom_range(POOL_BLOCKS - 1);
          fa = ADDR_W'(64'(pool_base) + 64'(idx) * 64'(blk_size));
        end else if (pick == 8) begin
          if (pool_base != 0 && $urandom_range(1) == 1)
            fa = pool_base - 1 - ADDR_W'({$urandom, $urandom} % 64'(pool_base));
          else
            fa = ADDR_W'(64'(pool_base) + region + 64'($urandom_range(0, 4095)));
        end
      end
      send_request(md, sz, fa, st);
      sent++;
      if (st == ST_EMPTY) empties++;
    end
  endtask

  task automatic test_directed_cases();
    status_e st;
    // reset settings: base 0, 64-byte blocks
    send_request(MODE_ALLOC, 32'd0, '0, st);
    send_request(MODE_ALLOC, 32'd65, '0, st);
    send_request(MODE_ALLOC, '1, '1, st);
    send_request(MODE_ALLOC, 32'd1, '1, st);
    send_request(MODE_ALLOC, 32'd64, '0, st);
    send_request(MODE_FREE, '1, 48'd1023 * 64 + 1, st);
    send_request(MODE_FREE, '0, 48'd1024 * 64, st);
    send_request(MODE_FREE, '0, '1, st);
    send_request(MODE_FREE, '0, 48'd5 * 64, st);
    send_request(MODE_FREE, '0, 48'd1023 * 64, st);
    send_request(MODE_FREE, '0, 48'd1023 * 64, st);
    send_request(MODE_ALLOC, 32'd32, '0, st);
    wait_idle();
    // smallest blocks, free below the base
    write_reg(CFG_SEL_BASE, 64'h0000_0000_0001_0000);
    write_reg(CFG_SEL_BSIZE, 64'd8);
    send_request(MODE_FREE, '0, '0, st);
    send_request(MODE_FREE, '0, 48'h0000_0000_FFF8, st);
    send_request(MODE_ALLOC, 32'd9, '0, st);
    send_request(MODE_ALLOC, 32'd8, '0, st);
    send_request(MODE_FREE, '0, 48'h1_0000 + 48'd8 * 1024, st);
    send_request(MODE_FREE, '0, 48'h1_0000 + 48'd8 * 1021 + 4, st);
    send_request(MODE_FREE, '0, 48'h1_0000 + 48'd8 * 1021, st);
    wait_idle();
    // largest blocks near the top of the address space: granted addresses wrap
    write_reg(CFG_SEL_BASE, 64'h0000_FFFF_FFF0_0000);
    write_reg(CFG_SEL_BSIZE, 64'd65536);
    send_request(MODE_ALLOC, 32'd65536, '0, st);
    send_request(MODE_ALLOC, 32'd65537, '0, st);
    send_request(MODE_FREE, '0, ADDR_W'(64'h0000_FFFF_FFF0_0000 + 64'd1021 * 65536), st);
    send_request(MODE_FREE, '0, 48'hFFFF_FFF0_0000, st);
    wait_idle();
  endtask

  task automatic test_drain_and_refill();
    status_e     st;
    int unsigned empties;
    int unsigned idx;
    write_reg(CFG_SEL_BASE, 64'h0000_0000_2468_1000);
    write_reg(CFG_SEL_BSIZE, 64'd8);
    jitter_on = 1'b0;
    // allocate until the pool has run dry four times, handing one block back each time
    empties = 0;
    while (empties < 4) begin
      send_request(MODE_ALLOC, SIZE_W'($urandom_range(1, blk_size)), '0, st);
      if (st == ST_EMPTY) begin
        empties++;
        if (held_blocks.size() != 0) begin
          idx = held_blocks[$urandom_range(held_blocks.size() - 1)];
          send_request(MODE_FREE, '0, ADDR_W'(64'(pool_base) + 64'(idx) * 64'(blk_size)), st);
        end
      end
    end
    jitter_on = 1'b1;
    random_traffic(40, 30, 0);
    wait_idle();
  endtask

  task automatic test_config_sweep();
    write_reg(CFG_SEL_BASE, 64'({$urandom, $urandom}) & 64'h0000_FFFF_FFFF_FFFF);
    write_reg(CFG_SEL_BSIZE, 64'd24);
    random_traffic(35, 55, 0);
    wait_idle();
    write_reg(CFG_SEL_BASE, 64'h0000_FFFF_FFFF_FFFF);
    write_reg(CFG_SEL_BSIZE, 64'd1000);
    random_traffic(35, 50, 0);
    wait_idle();
    write_reg(CFG_SEL_BASE, 64'd0);
    write_reg(CFG_SEL_BSIZE, 64'd65536);
    random_traffic(35, 50, 0);
    wait_idle();
    write_reg(CFG_SEL_BASE, 64'({$urandom, $urandom}) & 64'h0000_FFFF_FFFF_FFFF);
    write_reg(CFG_SEL_BSIZE, 64'($urandom_range(8, 65536)));
    random_traffic(35, 50, 0);
    wait_idle();
  endtask

  always @(negedge clk_i) rsp_ch.ready <= !(jitter_on && $urandom_range(99) < 37);

  always @(posedge clk_i) begin : response_check
    outcome_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (pool_outcomes.size() == 0) begin
        report_mismatch("response beat with none outstanding", '0, 64'(rsp_ch.status));
      end else begin
        want = pool_outcomes.pop_front();
        if (rsp_ch.status !== want.status)
          report_mismatch("status", 64'(want.status), 64'(rsp_ch.status));
        if (rsp_ch.block_address !== want.addr)
          report_mismatch("block_address", 64'(want.addr), 64'(rsp_ch.block_address));
        if (rsp_ch.block_index !== want.index)
          report_mismatch("block_index", 64'(want.index), 64'(rsp_ch.block_index));
        if (rsp_ch.blocks_free !== want.free_cnt)
          report_mismatch("blocks_free", 64'(want.free_cnt), 64'(rsp_ch.blocks_free));
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk_i);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : main_sequence
    req_ch.valid        = 1'b0;
    req_ch.mode         = MODE_ALLOC;
    req_ch.request_size = '0;
    req_ch.free_address = '0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    reset_pool_model();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed_cases();
    test_drain_and_refill();
    test_config_sweep();
    wait_idle();
    repeat (SETTLE_TICKS) @(posedge clk_i);
    if (mismatches == 0 && pool_outcomes.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/fbpa_pkg.sv
hdl/fbpa_if.sv
hdl/fbpa_cmd_fifo.sv
hdl/fbpa_front.sv
hdl/fbpa_back.sv
hdl/fixed_block_pool_allocator.sv
tb/sv/fixed_block_pool_allocator_test.sv
